// File: sv/control_packet_start_end_matcher_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef CONTROL_PACKET_START_END_MATCHER_MACROS_SVH
`define CONTROL_PACKET_START_END_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define CPSEM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define CPSEM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define CPSEM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CPSEM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: sv/cpsem_pkg.sv
// Shared widths, codes and types of the control packet matcher.
package cpsem_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam int ID_W    = 8;
   localparam int SEQ_W   = 16;
   localparam int TIME_W  = 48;
   localparam int PORT_W  = 6;
   localparam int STAMP_W = 16;
   localparam int DELAY_W = 32;
   localparam int STAT_W  = 2;
   // offset - now + arrival - delay stays within +/- 2^49
   localparam int SUM_W   = TIME_W + 2;

   localparam logic [STAT_W-1:0] STATUS_MATCH = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_MISS  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]           source;
      logic [SEQ_W-1:0]          seq;
      logic [TIME_W-1:0]         arrival;
      logic signed [TIME_W-1:0]  offset;
      logic [STAMP_W-1:0]        stamp;
   } entry_type;

   typedef struct packed {
      logic             write;
      logic             clear;
      logic [IDX_W-1:0] wr_idx;
      logic [IDX_W-1:0] clr_idx;
      logic [IDX_W-1:0] rd_idx;
   } tbl_cmd_type;

   typedef struct packed {
      logic             full;
      logic [IDX_W-1:0] free_idx;
   } tbl_stat_type;

endpackage

// File: sv/cpsem_if.sv
// Request and response channel interfaces of the control packet matcher.
interface cpsem_req_if import cpsem_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [ID_W-1:0]          burst_id;
   logic [SEQ_W-1:0]         seq_num;
   logic signed [TIME_W-1:0] burst_offset;
   logic [TIME_W-1:0]        now_time;
   logic [PORT_W-1:0]        in_port;

   modport source (output valid, cmd, burst_id, seq_num, burst_offset, now_time, in_port,
                   input ready);
   modport sink   (input valid, cmd, burst_id, seq_num, burst_offset, now_time, in_port,
                   output ready);
endinterface

interface cpsem_rsp_if import cpsem_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [ID_W-1:0]          out_burst_id;
   logic [SEQ_W-1:0]         out_seq_num;
   logic [PORT_W-1:0]        out_port;
   logic signed [TIME_W-1:0] adjusted_offset;
   logic [TIME_W-1:0]        emit_time;

   modport source (output valid, status, out_burst_id, out_seq_num, out_port,
                   adjusted_offset, emit_time, input ready);
   modport sink   (input valid, status, out_burst_id, out_seq_num, out_port,
                   adjusted_offset, emit_time, output ready);
endinterface

// File: sv/control_packet_start_end_matcher.sv
// Top level of the burst control packet start/end matcher.
//
// Pairs start and end control packets. A start transfer (cmd 0) is filed in a
// TABLE_DEPTH-entry pending table at the lowest free slot, stamped with a 16-bit
// insert counter; it gives no response unless the table is full (status 2).
// An end transfer (cmd 1) scans the table through its single read port, one
// entry per cycle, keeping the oldest matching entry (largest counter minus
// stamp, ties to the lowest slot). On a hit the entry is freed and one shared
// 50-bit adder works out offset - (now - arrival) - conversion_delay in three
// passes, saturated to 48-bit signed, then now + conversion_delay as the emit
// time. A miss answers with status 1, zero offset and zero emit time.
// One item is in work at a time; req ready is high only while idle. The
// response sits in an output register, so a new request is taken while it waits
// to be drained.
// conversion_delay is written through csr_wr_en/csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce it.
`include "control_packet_start_end_matcher_macros.svh"

module control_packet_start_end_matcher import cpsem_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [DELAY_W-1:0]  csr_wr_data,
   cpsem_req_if.sink           req_if,
   cpsem_rsp_if.source         rsp_if
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_CALC  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // adder passes
   localparam logic [1:0] PASS_OFS     = 2'd0;
   localparam logic [1:0] PASS_ARRIVAL = 2'd1;
   localparam logic [1:0] PASS_DELAY   = 2'd2;
   localparam logic [1:0] PASS_EMIT    = 2'd3;

   logic [2:0]               state_ff, state_in;
   logic [DELAY_W-1:0]       delay_ff, delay_in;
   logic [STAMP_W-1:0]       ins_cnt_ff, ins_cnt_in;

   // captured request
   logic                     cmd_ff, cmd_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic [SEQ_W-1:0]         seq_ff, seq_in;
   logic signed [TIME_W-1:0] offset_ff, offset_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [PORT_W-1:0]        port_ff, port_in;

   // scan and arithmetic
   logic [CNT_W-1:0]         scan_cnt_ff, scan_cnt_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0]       best_age_ff, best_age_in;
   logic [1:0]               pass_ff, pass_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;
   logic [STAT_W-1:0]        res_status_ff, res_status_in;
   logic signed [TIME_W-1:0] res_adj_ff, res_adj_in;
   logic [TIME_W-1:0]        res_emit_ff, res_emit_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]          rsp_id_ff, rsp_id_in;
   logic [SEQ_W-1:0]         rsp_seq_ff, rsp_seq_in;
   logic [PORT_W-1:0]        rsp_port_ff, rsp_port_in;
   logic signed [TIME_W-1:0] rsp_adj_ff, rsp_adj_in;
   logic [TIME_W-1:0]        rsp_emit_ff, rsp_emit_in;

   tbl_cmd_type              tbl_cmd;
   tbl_stat_type             tbl_stat;
   entry_type                wr_entry;
   entry_type                rd_entry;
   logic                     rd_valid;
   logic [TABLE_DEPTH-1:0]   valid_vec;

   logic signed [SUM_W-1:0]  alu_a, alu_b, alu_y;
   logic                     alu_sub;

   logic                     hit;
   logic [STAMP_W-1:0]       age;
   logic [IDX_W-1:0]         prev_idx;
   logic signed [TIME_W-1:0] sat_adj;
   logic                     store_start;
   logic                     fetch_hit;

   cpsem_table u_table (
      .clock     (clock),
      .reset     (reset),
      .tbl_cmd   (tbl_cmd),
      .wr_entry  (wr_entry),
      .rd_entry  (rd_entry),
      .rd_valid  (rd_valid),
      .tbl_stat  (tbl_stat),
      .valid_vec (valid_vec)
   );

   cpsem_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_y)
   );

   // entry being compared was read in the previous cycle
   assign prev_idx = IDX_W'(scan_cnt_ff - CNT_W'(1));
   assign hit      = rd_valid && (rd_entry.source == id_ff) && (rd_entry.seq == seq_ff);
   assign age      = ins_cnt_ff - rd_entry.stamp;

   // saturate to 48-bit signed: fits when the top three bits agree
   always_comb begin
      if ((acc_ff[SUM_W-1:TIME_W-1] == '0) || (acc_ff[SUM_W-1:TIME_W-1] == '1)) begin
         sat_adj = acc_ff[TIME_W-1:0];
      end else if (acc_ff[SUM_W-1]) begin
         sat_adj = {1'b1, {(TIME_W-1){1'b0}}};
      end else begin
         sat_adj = {1'b0, {(TIME_W-1){1'b1}}};
      end
   end

   assign wr_entry.source   = id_ff;
   assign wr_entry.seq      = seq_ff;
   assign wr_entry.arrival  = now_ff;
   assign wr_entry.offset   = offset_ff;
   assign wr_entry.stamp    = ins_cnt_ff;

   always_comb begin
      state_in      = state_ff;
      delay_in      = csr_wr_en ? csr_wr_data : delay_ff;
      ins_cnt_in    = ins_cnt_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      seq_in        = seq_ff;
      offset_in     = offset_ff;
      now_in        = now_ff;
      port_in       = port_ff;
      scan_cnt_in   = scan_cnt_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      pass_in       = pass_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_adj_in    = res_adj_ff;
      res_emit_in   = res_emit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_seq_in    = rsp_seq_ff;
      rsp_port_in   = rsp_port_ff;
      rsp_adj_in    = rsp_adj_ff;
      rsp_emit_in   = rsp_emit_ff;

      tbl_cmd.write   = 1'b0;
      tbl_cmd.clear   = 1'b0;
      tbl_cmd.wr_idx  = tbl_stat.free_idx;
      tbl_cmd.clr_idx = best_idx_ff;
      tbl_cmd.rd_idx  = best_idx_ff;

      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               cmd_in      = req_if.cmd;
               id_in       = req_if.burst_id;
               seq_in      = req_if.seq_num;
               offset_in   = req_if.burst_offset;
               now_in      = req_if.now_time;
               port_in     = req_if.in_port;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               state_in    = req_if.cmd ? ST_SCAN : ST_START;
            end
         end
         ST_START: begin
            if (tbl_stat.full) begin
               res_status_in = STATUS_FULL;
               res_adj_in    = '0;
               res_emit_in   = '0;
               state_in      = ST_DONE;
            end else begin
               tbl_cmd.write = 1'b1;
               ins_cnt_in    = ins_cnt_ff + STAMP_W'(1);
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff < CNT_W'(TABLE_DEPTH)) begin
               tbl_cmd.rd_idx = IDX_W'(scan_cnt_ff);
            end
            // strictly older wins, so ties keep the lower slot
            if ((scan_cnt_ff != '0) && hit && (!found_ff || (age > best_age_ff))) begin
               found_in    = 1'b1;
               best_idx_in = prev_idx;
               best_age_in = age;
            end
            if (scan_cnt_ff == CNT_W'(TABLE_DEPTH)) begin
               state_in = ST_FETCH;
            end else begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
         end
         ST_FETCH: begin
            if (found_ff) begin
               tbl_cmd.clear = 1'b1;
               pass_in       = PASS_OFS;
               state_in      = ST_CALC;
            end else begin
               res_status_in = STATUS_MISS;
               res_adj_in    = '0;
               res_emit_in   = '0;
               state_in      = ST_DONE;
            end
         end
         ST_CALC: begin
            pass_in = pass_ff + 2'd1;
            case (pass_ff)
               PASS_OFS: begin
                  alu_a   = SUM_W'(rd_entry.offset);
                  alu_b   = $signed({2'b00, now_ff});
                  alu_sub = 1'b1;
                  acc_in  = alu_y;
               end
               PASS_ARRIVAL: begin
                  alu_a  = acc_ff;
                  alu_b  = $signed({2'b00, rd_entry.arrival});
                  acc_in = alu_y;
               end
               PASS_DELAY: begin
                  alu_a   = acc_ff;
                  alu_b   = $signed({{(SUM_W-DELAY_W){1'b0}}, delay_ff});
                  alu_sub = 1'b1;
                  acc_in  = alu_y;
               end
               PASS_EMIT: begin
                  alu_a         = $signed({2'b00, now_ff});
                  alu_b         = $signed({{(SUM_W-DELAY_W){1'b0}}, delay_ff});
                  res_emit_in   = alu_y[TIME_W-1:0];
                  res_adj_in    = sat_adj;
                  res_status_in = STATUS_MATCH;
                  state_in      = ST_DONE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = id_ff;
               rsp_seq_in    = seq_ff;
               rsp_port_in   = port_ff;
               rsp_adj_in    = res_adj_ff;
               rsp_emit_in   = res_emit_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         delay_ff     <= '0;
         ins_cnt_ff   <= '0;
         scan_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         pass_ff      <= PASS_OFS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         delay_ff     <= delay_in;
         ins_cnt_ff   <= ins_cnt_in;
         scan_cnt_ff  <= scan_cnt_in;
         found_ff     <= found_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      seq_ff        <= seq_in;
      offset_ff     <= offset_in;
      now_ff        <= now_in;
      port_ff       <= port_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_adj_ff    <= res_adj_in;
      res_emit_ff   <= res_emit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_adj_ff    <= rsp_adj_in;
      rsp_emit_ff   <= rsp_emit_in;
   end

   assign req_if.ready           = (state_ff == ST_IDLE);
   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.out_burst_id    = rsp_id_ff;
   assign rsp_if.out_seq_num     = rsp_seq_ff;
   assign rsp_if.out_port        = rsp_port_ff;
   assign rsp_if.adjusted_offset = rsp_adj_ff;
   assign rsp_if.emit_time       = rsp_emit_ff;

   assign store_start = (state_ff == ST_START) && !tbl_stat.full;
   assign fetch_hit   = (state_ff == ST_FETCH) && found_ff;

   // a stored start marks its slot busy
   `CPSEM_ASSERT_NXT(a_start_fills, clock, reset, store_start, valid_vec[$past(tbl_stat.free_idx)])
   // a matched end frees the chosen slot
   `CPSEM_ASSERT_NXT(a_hit_frees, clock, reset, fetch_hit, !valid_vec[$past(best_idx_ff)])
   // insert counter moves only on a stored start
   `CPSEM_ASSERT_NXT(a_cnt_steady, clock, reset, !store_start, ins_cnt_ff == $past(ins_cnt_ff))
   // a new response is loaded only from the done state
   `CPSEM_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE)

endmodule

// File: sv/cpsem_table.sv
// Pending table: entry memory with one registered read port, valid flops, free slot pick.
module cpsem_table import cpsem_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  tbl_cmd_type            tbl_cmd,
   input  entry_type              wr_entry,
   output entry_type              rd_entry,
   output logic                   rd_valid,
   output tbl_stat_type           tbl_stat,
   output logic [TABLE_DEPTH-1:0] valid_vec
);

   entry_type                entry_mem [TABLE_DEPTH];
   entry_type                rd_entry_ff;
   logic                     rd_valid_ff;
   logic [TABLE_DEPTH-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (tbl_cmd.write) begin
         entry_mem[tbl_cmd.wr_idx] <= wr_entry;
      end
      rd_entry_ff <= entry_mem[tbl_cmd.rd_idx];
      rd_valid_ff <= valid_ff[tbl_cmd.rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (tbl_cmd.write) begin
            valid_ff[tbl_cmd.wr_idx] <= 1'b1;
         end
         if (tbl_cmd.clear) begin
            valid_ff[tbl_cmd.clr_idx] <= 1'b0;
         end
      end
   end

   // lowest free slot
   always_comb begin
      tbl_stat.full     = &valid_ff;
      tbl_stat.free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            tbl_stat.free_idx = IDX_W'(i);
         end
      end
   end

   assign rd_entry  = rd_entry_ff;
   assign rd_valid  = rd_valid_ff;
   assign valid_vec = valid_ff;

endmodule

// File: sv/cpsem_alu.sv
// Shared add/subtract unit for the offset and emit time arithmetic.
module cpsem_alu import cpsem_pkg::*; (
   input  logic signed [SUM_W-1:0] op_a,
   input  logic signed [SUM_W-1:0] op_b,
   input  logic                    sub,
   output logic signed [SUM_W-1:0] result
);

   logic signed [SUM_W-1:0] b_eff;

   assign b_eff  = sub ? ~op_b : op_b;
   assign result = op_a + b_eff + SUM_W'(sub);

endmodule
